/* rtl/core/rsch_pkg.sv */
package rsch_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_W        = 160;  // working width of the exact integer datapath
  localparam int MUL_W         = 72;   // serial multiplier operand, holds K and H signed
  localparam int REM_W         = 66;   // divider remainder, above the widest D.D
  localparam int CFG_IDX_W     = 4;

  localparam logic [31:0] ID_NONE  = '1;
  localparam logic [30:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 4'd0,
    REG_ORIGIN_Y    = 4'd1,
    REG_ORIGIN_Z    = 4'd2,
    REG_DIR_X       = 4'd3,
    REG_DIR_Y       = 4'd4,
    REG_DIR_Z       = 4'd5,
    REG_MAX_DIST    = 4'd6,
    REG_EXCLUDED_ID = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] radius;
    logic [31:0]        entity_id;
    logic               last;
  } sphere_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_id;
    logic [30:0] hit_distance;
  } result_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        max_distance;
    logic [31:0]        excluded_id;
  } ray_cfg_t;

  // classified sphere handed from front to back
  typedef struct packed {
    logic               skip;
    logic               last;
    logic [31:0]        id;
    logic signed [32:0] oc_x;
    logic signed [32:0] oc_y;
    logic signed [32:0] oc_z;
    logic signed [31:0] radius;
  } job_t;

endpackage

/* rtl/core/rsch_front.sv */
module rsch_front import rsch_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ray_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  sphere_t  in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  localparam logic signed [31:0] RAD_HALF = 32'(1) << (FRAC_BITS - 1);

  job_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  job_t       entry;
  logic       push;
  logic       pop;

  always_comb begin
    entry.skip   = (cfg.excluded_id != ID_NONE) && (in_data.entity_id == cfg.excluded_id);
    entry.last   = in_data.last;
    entry.id     = in_data.entity_id;
    entry.oc_x   = 33'(cfg.origin_x) - 33'(in_data.center_x);
    entry.oc_y   = 33'(cfg.origin_y) - 33'(in_data.center_y);
    entry.oc_z   = 33'(cfg.origin_z) - 33'(in_data.center_z);
    entry.radius = (in_data.radius <= 0) ? RAD_HALF : in_data.radius;
  end

  assign in_ready  = (count != 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q_mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/core/rsch_back.sv */
module rsch_back import rsch_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  ray_cfg_t cfg,
  input  logic     job_valid,
  output logic     job_ready,
  input  job_t     job,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_data
);

  localparam int NUM_W    = 69 + FRAC_BITS;
  localparam int SQ_STEPS = WIDE_W / 2;
  localparam int CNT_MAX  = (NUM_W > SQ_STEPS) ? NUM_W : SQ_STEPS;
  localparam int CNT_W    = $clog2(CNT_MAX);
  localparam int LAST_P   = 11;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_MUL, S_CHECK, S_SQRT, S_ROOT, S_DIV, S_CMP
  } state_t;
  typedef enum logic [1:0] {T_A, T_H, T_K, T_D} tgt_t;

  state_t                    state;
  logic                      done;   // sphere finished, result pending if last
  job_t                      job_r;
  logic [3:0]                p;
  logic [CNT_W-1:0]          cnt;
  logic [WIDE_W-1:0]         acc, mc, a_r, h_r, k_r, disc_r;
  logic [MUL_W-1:0]          mp;
  logic [WIDE_W-1:0]         sq_num, sq_res, sq_bit;
  logic                      far;
  logic [NUM_W-1:0]          dnum;
  logic [REM_W-1:0]          rem;
  logic [31:0]               q;
  logic                      ovf;
  logic                      found;
  logic [31:0]               best_id;
  logic [30:0]               best_dist;

  logic signed [WIDE_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  tgt_t                      tgt;
  logic                      neg;
  logic [WIDE_W-1:0]         tgt_val, acc_next, sq_t, root_num;
  logic [REM_W:0]            r2;
  logic                      ge;
  logic [30:0]               t_val;
  logic [30:0]               limit;
  logic                      emit;

  // product schedule: A = D.D, H = oc.D, K = oc.oc - r*r, disc = H*H - A*K
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tgt   = T_A;
    neg   = 1'b0;
    case (p)
      4'd0: begin mul_a = WIDE_W'(cfg.dir_x); mul_b = MUL_W'(cfg.dir_x); end
      4'd1: begin mul_a = WIDE_W'(cfg.dir_y); mul_b = MUL_W'(cfg.dir_y); end
      4'd2: begin mul_a = WIDE_W'(cfg.dir_z); mul_b = MUL_W'(cfg.dir_z); end
      4'd3: begin mul_a = WIDE_W'(job_r.oc_x); mul_b = MUL_W'(cfg.dir_x); tgt = T_H; end
      4'd4: begin mul_a = WIDE_W'(job_r.oc_y); mul_b = MUL_W'(cfg.dir_y); tgt = T_H; end
      4'd5: begin mul_a = WIDE_W'(job_r.oc_z); mul_b = MUL_W'(cfg.dir_z); tgt = T_H; end
      4'd6: begin mul_a = WIDE_W'(job_r.oc_x); mul_b = MUL_W'(job_r.oc_x); tgt = T_K; end
      4'd7: begin mul_a = WIDE_W'(job_r.oc_y); mul_b = MUL_W'(job_r.oc_y); tgt = T_K; end
      4'd8: begin mul_a = WIDE_W'(job_r.oc_z); mul_b = MUL_W'(job_r.oc_z); tgt = T_K; end
      4'd9: begin
        mul_a = WIDE_W'(job_r.radius); mul_b = MUL_W'(job_r.radius); tgt = T_K; neg = 1'b1;
      end
      4'd10: begin mul_a = h_r; mul_b = h_r[MUL_W-1:0]; tgt = T_D; end
      4'd11: begin mul_a = a_r; mul_b = k_r[MUL_W-1:0]; tgt = T_D; neg = 1'b1; end
      default: begin end
    endcase
    case (tgt)
      T_A:     tgt_val = a_r;
      T_H:     tgt_val = h_r;
      T_K:     tgt_val = k_r;
      default: tgt_val = disc_r;
    endcase
  end

  always_comb begin
    // top multiplier bit carries negative weight
    if (!mp[0]) acc_next = acc;
    else if (cnt == CNT_W'(MUL_W - 1)) acc_next = acc - mc;
    else acc_next = acc + mc;
    sq_t     = sq_res + sq_bit;
    root_num = far ? (sq_res - h_r) : ('0 - h_r - sq_res);
    r2       = {rem, dnum[NUM_W-1]};
    ge       = (r2 >= a_r[REM_W:0]);
    t_val    = (ovf || q[31]) ? DIST_MAX : q[30:0];
    limit    = found ? best_dist : cfg.max_distance;
  end

  assign job_ready = (state == S_IDLE) && !done;
  assign emit      = (state == S_IDLE) && done && job_r.last && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      found     <= 1'b0;
      best_id   <= ID_NONE;
      best_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (done) begin
            if (!job_r.last) begin
              done <= 1'b0;
            end else if (!out_valid || out_ready) begin
              out_valid             <= 1'b1;
              out_data.hit          <= found;
              out_data.hit_id       <= found ? best_id : ID_NONE;
              out_data.hit_distance <= found ? best_dist : '0;
              found                 <= 1'b0;
              best_id               <= ID_NONE;
              best_dist             <= '0;
              done                  <= 1'b0;
            end
          end else if (job_valid) begin
            job_r  <= job;
            a_r    <= '0;
            h_r    <= '0;
            k_r    <= '0;
            disc_r <= '0;
            p      <= '0;
            if (job.skip) done <= 1'b1;
            else state <= S_START;
          end
        end
        S_START: begin
          acc   <= tgt_val;
          mc    <= neg ? ('0 - mul_a) : mul_a;
          mp    <= mul_b;
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= acc_next;
          mc  <= mc << 1;
          mp  <= mp >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_W - 1)) begin
            case (tgt)
              T_A:     a_r    <= acc_next;
              T_H:     h_r    <= acc_next;
              T_K:     k_r    <= acc_next;
              default: disc_r <= acc_next;
            endcase
            p     <= p + 1'b1;
            state <= (p == 4'(LAST_P)) ? S_CHECK : S_START;
          end
        end
        S_CHECK: begin
          // zero direction or negative discriminant: no hit
          if ((a_r == '0) || disc_r[WIDE_W-1]) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            sq_num <= disc_r;
            sq_res <= '0;
            sq_bit <= WIDE_W'(1) << (WIDE_W - 2);
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_num >= sq_t) begin
            sq_num <= sq_num - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(SQ_STEPS - 1)) begin
            far   <= 1'b0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!root_num[WIDE_W-1] && (root_num != '0)) begin
            dnum  <= {root_num[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            rem   <= '0;
            q     <= '0;
            ovf   <= 1'b0;
            cnt   <= '0;
            state <= S_DIV;
          end else if (!far) begin
            far <= 1'b1;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rem  <= ge ? REM_W'(r2 - a_r[REM_W:0]) : r2[REM_W-1:0];
          q    <= {q[30:0], ge};
          ovf  <= ovf | q[31];
          dnum <= dnum << 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) state <= S_CMP;
        end
        S_CMP: begin
          if ((t_val == '0) && !far) begin
            far   <= 1'b1;
            state <= S_ROOT;
          end else begin
            if ((t_val != '0) && (t_val < limit)) begin
              found     <= 1'b1;
              best_dist <= t_val;
              best_id   <= job_r.id;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ray_sphere_closest_hit.sv */
// channel  dir  handshake             payload
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in   in_valid/in_ready     in_data  (sphere_t)
// out      out  out_valid/out_ready   out_data (result_t)
//
// The back end works on one sphere at a time, using its shared bit-serial
// multiplier, square root and divider. Excluded spheres skip all three.
// A two-entry queue lets the front accept spheres while the back is busy.
// Reset is synchronous; it restores the register defaults and clears the search.
// cfg_ready is always high; a pending result stalls the back end only on last.
module ray_sphere_closest_hit import rsch_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sphere_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_data
);

  ray_cfg_t cfg;
  logic     job_valid;
  logic     job_ready;
  job_t     job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.origin_z     <= '0;
      cfg.dir_x        <= '0;
      cfg.dir_y        <= '0;
      cfg.dir_z        <= 32'sd1 <<< FRAC_BITS;
      cfg.max_distance <= 31'd3 << FRAC_BITS;
      cfg.excluded_id  <= ID_NONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:    cfg.origin_x     <= cfg_data;
        REG_ORIGIN_Y:    cfg.origin_y     <= cfg_data;
        REG_ORIGIN_Z:    cfg.origin_z     <= cfg_data;
        REG_DIR_X:       cfg.dir_x        <= cfg_data;
        REG_DIR_Y:       cfg.dir_y        <= cfg_data;
        REG_DIR_Z:       cfg.dir_z        <= cfg_data;
        REG_MAX_DIST:    cfg.max_distance <= cfg_data[30:0];
        REG_EXCLUDED_ID: cfg.excluded_id  <= cfg_data;
        default: begin end
      endcase
    end
  end

  rsch_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  rsch_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
